@@ design/sfq_pkg.sv @@
// Shared types and constants for the sortable FIFO queue.
// No dependencies; imported by every module of the block.
package sfq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned EntryCountW = 5;
  localparam int unsigned CountW      = $clog2(DEPTH + 1);
  localparam int unsigned PhaseW      = $clog2(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_ROTATE = 2'd2,
    OP_SORT   = 2'd3
  } sfq_op_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } sfq_status_e;

  typedef enum logic [1:0] {
    STATE_RUN,
    STATE_SORT,
    STATE_REPORT
  } sfq_state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_SORT_LO,
    CELL_SORT_HI
  } sfq_cell_cmd_e;

  typedef struct packed {
    sfq_op_e                  op;
    logic signed [ValueW-1:0] value;
  } sfq_in_t;

  typedef struct packed {
    sfq_status_e               status;
    logic signed [ValueW-1:0]  front_value;
    logic                      front_valid;
    logic [EntryCountW-1:0]    entry_count;
  } sfq_out_t;

  typedef struct packed {
    sfq_cell_cmd_e            cmd;
    logic signed [ValueW-1:0] load_value;
  } sfq_cell_ctrl_t;

endpackage

@@ design/sfq_cell.sv @@
// One storage cell of the queue chain: holds a value, shifts toward the front,
// loads, or takes part in one compare-exchange of an odd-even sort.
// Depends on sfq_pkg.
module sfq_cell import sfq_pkg::*; (
  input  logic                     clk_i,
  input  sfq_cell_ctrl_t           ctrl_i,
  input  logic signed [ValueW-1:0] left_value_i,
  input  logic signed [ValueW-1:0] right_value_i,
  output logic signed [ValueW-1:0] value_o
);

  logic signed [ValueW-1:0] value_q, value_d;

  always_comb begin
    case (ctrl_i.cmd)
      CELL_LOAD:    value_d = ctrl_i.load_value;
      CELL_SHIFT:   value_d = right_value_i;
      // lower cell of a pair keeps the smaller; swap only on strict order
      CELL_SORT_LO: value_d = (value_q > right_value_i) ? right_value_i : value_q;
      CELL_SORT_HI: value_d = (left_value_i > value_q) ? left_value_i : value_q;
      default:      value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ design/sortable_fifo_queue_core.sv @@
// Sortable FIFO queue: push, pop and rotate are taken one per cycle unless
// in_stall_o is high; the result request appears on the output register the
// cycle after acceptance. A sort runs DEPTH odd-even transposition phases over
// the cell chain and then a report state, holding the input stalled throughout.
// Reset empties the queue and clears the output valid; cell contents are not reset.
module sortable_fifo_queue_core import sfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sfq_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sfq_out_t out_req_o
);

  // Queue order is kept physically: cell 0 is the front, cell count-1 the rear.
  sfq_state_e              state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [PhaseW-1:0]       phase_q, phase_d;
  logic                    out_valid_q;
  sfq_out_t                out_q, out_d;
  logic                    out_load;
  logic                    out_free;
  logic                    in_fire;
  logic                    full;
  logic                    empty;
  logic signed [ValueW-1:0] load_value;

  logic signed [ValueW-1:0] cell_value [DEPTH];
  sfq_cell_ctrl_t           cell_ctrl  [DEPTH];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == STATE_RUN) && out_free);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign full       = (count_q == CountW'(DEPTH));
  assign empty      = (count_q == '0);

  // push loads the new value at the rear; rotate re-enters the old front there
  assign load_value = (in_req_i.op == OP_PUSH) ? in_req_i.value : cell_value[0];

  // ---------------------------------------------------------------------------
  // Sequencer: operation decode, sort phase counting, result formation
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    phase_d  = phase_q;
    out_load = 1'b0;
    out_d.status      = STATUS_DONE;
    out_d.front_value = '0;
    out_d.front_valid = 1'b0;
    out_d.entry_count = '0;

    case (state_q)
      STATE_RUN: begin
        if (in_fire) begin
          out_load = 1'b1;
          case (in_req_i.op)
            OP_PUSH: begin
              if (full) begin
                out_d.status      = STATUS_FULL;
                out_d.front_value = cell_value[0];
              end else begin
                count_d           = count_q + 1'b1;
                out_d.front_value = empty ? in_req_i.value : cell_value[0];
              end
            end
            OP_POP: begin
              if (empty) begin
                out_d.status = STATUS_EMPTY;
              end else begin
                count_d           = count_q - 1'b1;
                out_d.front_value = (count_q == CountW'(1)) ? '0 : cell_value[1];
              end
            end
            OP_ROTATE: begin
              if (empty) begin
                out_d.status = STATUS_EMPTY;
              end else begin
                // a single entry rotates onto itself
                out_d.front_value = (count_q == CountW'(1)) ? cell_value[0]
                                                            : cell_value[1];
              end
            end
            default: begin
              // sort: result is reported once the phases are done
              out_load = 1'b0;
              phase_d  = '0;
              state_d  = STATE_SORT;
            end
          endcase
          out_d.front_valid = (count_d != '0);
          out_d.entry_count = EntryCountW'(count_d);
        end
      end
      STATE_SORT: begin
        phase_d = phase_q + 1'b1;
        if (phase_q == PhaseW'(DEPTH - 1)) begin
          state_d = STATE_REPORT;
        end
      end
      STATE_REPORT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.front_value = empty ? '0 : cell_value[0];
          out_d.front_valid = !empty;
          out_d.entry_count = EntryCountW'(count_q);
          state_d           = STATE_RUN;
        end
      end
      default: begin
        state_d = STATE_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RUN;
      count_q     <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // ---------------------------------------------------------------------------
  // Cell chain. Each cell gets a command from its position relative to the
  // entry count. Sorting pairs cells (i, i+1) whose lower index matches the
  // phase parity; only pairs fully inside the occupied range exchange.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueW-1:0] left_value;
    logic signed [ValueW-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_left
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_right
      assign right_value = cell_value[i+1];
    end

    always_comb begin
      cell_ctrl[i].cmd        = CELL_HOLD;
      cell_ctrl[i].load_value = load_value;
      if (state_q == STATE_SORT) begin
        if ((1'(i % 2) == phase_q[0]) && (CountW'(i + 1) < count_q)) begin
          cell_ctrl[i].cmd = CELL_SORT_LO;
        end else if ((i >= 1) && (1'((i + 1) % 2) == phase_q[0]) &&
                     (CountW'(i) < count_q)) begin
          cell_ctrl[i].cmd = CELL_SORT_HI;
        end
      end else if (in_fire) begin
        case (in_req_i.op)
          OP_PUSH: begin
            if (!full && (count_q == CountW'(i))) begin
              cell_ctrl[i].cmd = CELL_LOAD;
            end
          end
          OP_POP: begin
            if (!empty) begin
              cell_ctrl[i].cmd = CELL_SHIFT;
            end
          end
          OP_ROTATE: begin
            if (!empty) begin
              if (CountW'(i + 1) == count_q) begin
                cell_ctrl[i].cmd = CELL_LOAD;
              end else if (CountW'(i + 1) < count_q) begin
                cell_ctrl[i].cmd = CELL_SHIFT;
              end
            end
          end
          default: begin
            cell_ctrl[i].cmd = CELL_HOLD;
          end
        endcase
      end
    end

    sfq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl[i]),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .value_o       (cell_value[i])
    );
  end

endmodule

@@ design/sfq_checker.sv @@
// Port-level checks for the sortable FIFO queue, bound to the top level.
// Depends on sfq_pkg and sortable_fifo_queue_core.
module sfq_checker import sfq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sfq_out_t out_req_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_req_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_req_o))
    else $error("result request changed while stalled");

  a_front_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.front_valid == (out_req_o.entry_count != '0)))
    else $error("front_valid disagrees with entry_count");

  a_empty_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.front_valid |-> (out_req_o.front_value == '0))
    else $error("empty queue reports nonzero front");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.status == STATUS_EMPTY) |-> (out_req_o.entry_count == '0))
    else $error("empty status with entries held");

endmodule

bind sortable_fifo_queue_core sfq_checker u_sfq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
